// ===== rtl/lfa_pkg.sv =====
// Package: sizes, codes and inter-module structs of the lowest free id allocator.
package lfa_pkg;

  // Pool size and the layout of the bitmaps across the cell chain
  localparam int MAX_IDS    = 256;
  localparam int NCELLS     = 16;
  localparam int CELL_W     = MAX_IDS / NCELLS;
  localparam int ID_W       = $clog2(MAX_IDS + 1);
  localparam int CELL_IDX_W = $clog2(NCELLS);
  localparam int BIT_W      = $clog2(CELL_W);
  localparam int IDX_W      = CELL_IDX_W + BIT_W;

  // Request modes
  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_CLAIM   = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_TAKEN     = 2'd1;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd2;
  localparam logic [1:0] STAT_NOT_HELD  = 2'd3;

  // Search token that walks the cell chain
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] target;
    logic             found;
    logic [IDX_W-1:0] found_idx;
    logic             hit;
  } tok_t;

  // Bitmap update broadcast to all cells
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic             take;
  } wr_t;

endpackage

// ===== rtl/lfa_if.sv =====
// Interfaces: request and response channels of the allocator.
interface lfa_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                mode;
  logic [lfa_pkg::ID_W-1:0]  req_id;

  modport source (output valid, mode, req_id, input ready);
  modport sink   (input valid, mode, req_id, output ready);
endinterface

interface lfa_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [lfa_pkg::ID_W-1:0]  out_id;
  logic [1:0]                status;

  modport source (output valid, out_id, status, input ready);
  modport sink   (input valid, out_id, status, output ready);
endinterface

// ===== rtl/lowest_free_id_allocator.sv =====
// Top level: lowest free id allocator built from a chain of bitmap cells.
//
// Usage: requests arrive on in_req (mode, req_id) with valid/ready; each
// transaction yields exactly one response on out_rsp (out_id, status).
// Mode allocate returns the lowest released id, else the high-water mark
// plus one, else status exhausted. Mode claim takes req_id, mode release
// returns req_id to the freed pool.
// The search token crosses all 16 cells, registered in each; the controller
// then registers its decision and loads the output register.
// A new request is taken only once the last result has reached the output register.
// in_req.ready is high only while no request is in flight, so a finished
// response may wait on out_rsp while the next request is taken.
// Reset clears both bitmaps, the high-water mark and all valid flags at once.
// When the receiver stalls, the response holds in the output register and
// the next result waits in the controller until the register frees up.
module lowest_free_id_allocator (
  input  logic       clk,
  input  logic       rst_n,
  lfa_req_if.sink    in_req,
  lfa_rsp_if.source  out_rsp
);

  lfa_pkg::tok_t tok [lfa_pkg::NCELLS+1];
  lfa_pkg::wr_t  wr;

  // Intake, decision and output register
  lfa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_req.valid),
    .in_ready   (in_req.ready),
    .in_mode    (in_req.mode),
    .in_req_id  (in_req.req_id),
    .tok_inj    (tok[0]),
    .tok_last   (tok[lfa_pkg::NCELLS]),
    .wr         (wr),
    .out_valid  (out_rsp.valid),
    .out_ready  (out_rsp.ready),
    .out_id     (out_rsp.out_id),
    .out_status (out_rsp.status)
  );

  // Chain of bitmap cells
  for (genvar g = 0; g < lfa_pkg::NCELLS; g++) begin : g_cell
    lfa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (lfa_pkg::CELL_IDX_W'(g)),
      .tok_in   (tok[g]),
      .tok_out  (tok[g+1]),
      .wr       (wr)
    );
  end

endmodule

// ===== rtl/lfa_cell.sv =====
// Cell: one slice of the assigned and freed bitmaps plus one token stage.
module lfa_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [lfa_pkg::CELL_IDX_W-1:0] cell_idx,
  input  lfa_pkg::tok_t                  tok_in,
  output lfa_pkg::tok_t                  tok_out,
  input  lfa_pkg::wr_t                   wr
);

  logic [lfa_pkg::CELL_W-1:0] assigned_r;
  logic [lfa_pkg::CELL_W-1:0] freed_r;
  lfa_pkg::tok_t              tok_r;
  lfa_pkg::tok_t              tok_nxt;
  logic [lfa_pkg::BIT_W-1:0]  low_bit;
  logic [lfa_pkg::BIT_W-1:0]  tgt_bit;
  logic [lfa_pkg::BIT_W-1:0]  wr_bit;
  logic                       tgt_here;
  logic                       wr_here;

  assign tgt_bit  = tok_in.target[lfa_pkg::BIT_W-1:0];
  assign tgt_here = tok_in.target[lfa_pkg::IDX_W-1:lfa_pkg::BIT_W] == cell_idx;
  assign wr_bit   = wr.idx[lfa_pkg::BIT_W-1:0];
  assign wr_here  = wr.en && (wr.idx[lfa_pkg::IDX_W-1:lfa_pkg::BIT_W] == cell_idx);

  // Find the lowest freed bit of this slice
  always_comb begin
    low_bit = '0;
    for (int i = lfa_pkg::CELL_W - 1; i >= 0; i--) begin
      if (freed_r[i]) begin
        low_bit = lfa_pkg::BIT_W'(i);
      end
    end
  end

  // Update the token as it passes this slice
  always_comb begin
    tok_nxt = tok_in;
    if (!tok_in.found && (|freed_r)) begin
      tok_nxt.found     = 1'b1;
      tok_nxt.found_idx = {cell_idx, low_bit};
    end
    if (tgt_here) begin
      tok_nxt.hit = assigned_r[tgt_bit];
    end
  end

  // Advance the token to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.target    <= tok_nxt.target;
    tok_r.found     <= tok_nxt.found;
    tok_r.found_idx <= tok_nxt.found_idx;
    tok_r.hit       <= tok_nxt.hit;
  end

  assign tok_out = tok_r;

  // Apply the broadcast bitmap update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      assigned_r <= '0;
      freed_r    <= '0;
    end else if (wr_here) begin
      assigned_r[wr_bit] <= wr.take;
      freed_r[wr_bit]    <= !wr.take;
    end
  end

endmodule

// ===== rtl/lfa_ctrl.sv =====
// Controller: request intake, token injection, decision, high-water mark and result register.
module lfa_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_mode,
  input  logic [lfa_pkg::ID_W-1:0] in_req_id,
  output lfa_pkg::tok_t            tok_inj,
  input  lfa_pkg::tok_t            tok_last,
  output lfa_pkg::wr_t             wr,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [lfa_pkg::ID_W-1:0] out_id,
  output logic [1:0]               out_status
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [lfa_pkg::ID_W-1:0] MAX_ID = lfa_pkg::ID_W'(lfa_pkg::MAX_IDS);
  localparam logic [lfa_pkg::ID_W-1:0] ONE    = lfa_pkg::ID_W'(1);

  logic [1:0]               state_r, state_nxt;
  logic [1:0]               mode_r;
  logic [lfa_pkg::ID_W-1:0] req_r;
  logic [lfa_pkg::ID_W-1:0] hw_r, hw_nxt;
  logic [lfa_pkg::ID_W-1:0] res_id_r, res_id_nxt;
  logic [1:0]               res_st_r, res_st_nxt;
  logic                     out_valid_r;
  logic [lfa_pkg::ID_W-1:0] out_id_r;
  logic [1:0]               out_st_r;
  logic                     accept;
  logic                     decide;
  logic                     in_range;
  logic                     out_free;
  logic [lfa_pkg::ID_W-1:0] found_id;

  assign accept   = in_valid && in_ready;
  assign in_ready = state_r == S_IDLE;
  assign decide   = (state_r == S_SCAN) && tok_last.valid;
  assign out_free = !out_valid_r || out_ready;
  assign in_range = (req_r != '0) && (req_r <= MAX_ID);
  assign found_id = lfa_pkg::ID_W'(tok_last.found_idx) + ONE;

  // Inject a fresh token into the first cell on acceptance
  always_comb begin
    tok_inj           = '0;
    tok_inj.valid     = accept;
    tok_inj.target    = in_req_id[lfa_pkg::IDX_W-1:0] - lfa_pkg::IDX_W'(1);
  end

  // Decide the result once the token leaves the last cell
  always_comb begin
    res_id_nxt = res_id_r;
    res_st_nxt = res_st_r;
    hw_nxt     = hw_r;
    wr         = '0;
    if (decide) begin
      res_id_nxt = '0;
      res_st_nxt = lfa_pkg::STAT_OK;
      case (mode_r)
        lfa_pkg::MODE_ALLOC: begin
          if (tok_last.found) begin
            res_id_nxt = found_id;
          end else if (hw_r < MAX_ID) begin
            res_id_nxt = hw_r + ONE;
          end else begin
            res_st_nxt = lfa_pkg::STAT_EXHAUSTED;
          end
          if (res_st_nxt == lfa_pkg::STAT_OK) begin
            wr.en   = 1'b1;
            wr.idx  = res_id_nxt[lfa_pkg::IDX_W-1:0] - lfa_pkg::IDX_W'(1);
            wr.take = 1'b1;
            if (res_id_nxt > hw_r) begin
              hw_nxt = res_id_nxt;
            end
          end
        end
        lfa_pkg::MODE_CLAIM: begin
          if (!in_range) begin
            res_st_nxt = lfa_pkg::STAT_EXHAUSTED;
          end else if (tok_last.hit) begin
            res_id_nxt = req_r;
            res_st_nxt = lfa_pkg::STAT_TAKEN;
          end else begin
            res_id_nxt = req_r;
            wr.en      = 1'b1;
            wr.idx     = tok_last.target;
            wr.take    = 1'b1;
            if (req_r > hw_r) begin
              hw_nxt = req_r;
            end
          end
        end
        lfa_pkg::MODE_RELEASE: begin
          if (!in_range || !tok_last.hit) begin
            res_st_nxt = lfa_pkg::STAT_NOT_HELD;
          end else begin
            res_id_nxt = req_r;
            wr.en      = 1'b1;
            wr.idx     = tok_last.target;
            wr.take    = 1'b0;
          end
        end
        default: begin
          res_id_nxt = '0;
        end
      endcase
    end
  end

  // Sequence intake, scan and hand-off
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (decide) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hw_r    <= hw_nxt;
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      req_r  <= in_req_id;
    end
    res_id_r <= res_id_nxt;
    res_st_r <= res_st_nxt;
    if ((state_r == S_DONE) && out_free) begin
      out_id_r <= res_id_r;
      out_st_r <= res_st_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_id     = out_id_r;
  assign out_status = out_st_r;

endmodule

// ===== rtl/lfa_checker.sv =====
// Checker: port-level assertions of the allocator, bound to the top level.
module lfa_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [lfa_pkg::ID_W-1:0] out_id,
  input logic [1:0]               status
);

  // Hold a stalled response
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_id) && $stable(status))
    else $error("stalled response changed");

  // Take one request at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  // Raise a response only after a busy cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("response without a request in flight");

  // Report no id on failed release or exhaustion
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == lfa_pkg::STAT_NOT_HELD || status == lfa_pkg::STAT_EXHAUSTED)
    |-> out_id == '0)
    else $error("failure status with nonzero id");

  // Report a nonzero id with an already-assigned status
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == lfa_pkg::STAT_TAKEN) |-> out_id != '0)
    else $error("taken status without an id");

endmodule

bind lowest_free_id_allocator lfa_checker u_lfa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .out_id    (out_rsp.out_id),
  .status    (out_rsp.status)
);

// ===== tb/sv/id_grant_checker.sv =====
`timescale 1ns / 1ps
// Checker: tracks the id pool, predicts each response and compares it with the DUT.
module id_grant_checker
  import lfa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  lfa_req_if   req_mon,
  lfa_rsp_if   rsp_mon,
  output int   fail_count,
  output int   grants_due
);

  // One predicted response, tagged with the request that caused it
  typedef struct packed {
    logic [1:0]      mode;
    logic [ID_W-1:0] req_id;
    logic [ID_W-1:0] id;
    logic [1:0]      status;
  } grant_t;

  // Pool state: id n lives at index n
  bit              held_map  [1:MAX_IDS];
  bit              freed_map [1:MAX_IDS];
  logic [ID_W-1:0] high_water;
  grant_t          due_grants [$];

  task automatic report_mismatch(input string what, input int got, input int want,
                                 input grant_t g);
    if (fail_count < 40)
      $display("%0t ns: %s got %0d, want %0d (mode %0d, req_id %0d)",
               $time, what, got, want, g.mode, g.req_id);
    fail_count++;
  endtask

  // Mark an id in use; a reused id leaves the freed pool
  task automatic take_id(input logic [ID_W-1:0] id);
    held_map[id]  = 1'b1;
    freed_map[id] = 1'b0;
    if (id > high_water)
      high_water = id;
  endtask

  // Apply one request to the pool and work out its response
  task automatic predict_grant(input logic [1:0] mode, input logic [ID_W-1:0] req_id,
                               output grant_t g);
    bit found;
    g = '0;
    g.mode   = mode;
    g.req_id = req_id;
    g.status = STAT_OK;
    found    = 1'b0;
    case (mode)
      MODE_ALLOC: begin
        // lowest freed id first, then grow the high-water mark
        for (int k = 1; k <= MAX_IDS && !found; k++) begin
          if (freed_map[k]) begin
            g.id  = ID_W'(k);
            found = 1'b1;
          end
        end
        if (!found) begin
          if (high_water < MAX_IDS)
            g.id = high_water + 1'b1;
          else
            g.status = STAT_EXHAUSTED;
        end
        if (g.id != '0)
          take_id(g.id);
      end
      MODE_CLAIM: begin
        if (req_id == '0 || req_id > MAX_IDS) begin
          g.status = STAT_EXHAUSTED;
        end else if (held_map[req_id]) begin
          g.id     = req_id;
          g.status = STAT_TAKEN;
        end else begin
          g.id = req_id;
          take_id(req_id);
        end
      end
      MODE_RELEASE: begin
        if (req_id == '0 || req_id > MAX_IDS || !held_map[req_id]) begin
          g.status = STAT_NOT_HELD;
        end else begin
          held_map[req_id]  = 1'b0;
          freed_map[req_id] = 1'b1;
          g.id = req_id;
        end
      end
      default: begin
        // spare mode: no change, empty ok response
      end
    endcase
  endtask

  // Check responses against the oldest prediction, then queue new requests
  always @(posedge clk) begin
    grant_t g;
    if (!rst_n) begin
      for (int k = 1; k <= MAX_IDS; k++) begin
        held_map[k]  = 1'b0;
        freed_map[k] = 1'b0;
      end
      high_water = '0;
      due_grants.delete();
      fail_count = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (due_grants.size() == 0) begin
          report_mismatch("unexpected response, out_id", rsp_mon.out_id, 0, '0);
        end else begin
          g = due_grants[0];
          due_grants.delete(0);
          if (rsp_mon.out_id !== g.id)
            report_mismatch("out_id", rsp_mon.out_id, g.id, g);
          if (rsp_mon.status !== g.status)
            report_mismatch("status", rsp_mon.status, g.status, g);
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        predict_grant(req_mon.mode, req_mon.req_id, g);
        due_grants.insert(due_grants.size(), g);
      end
    end
    grants_due = due_grants.size();
  end

endmodule

// ===== tb/sv/lowest_free_id_allocator_test.sv =====
`timescale 1ns / 1ps
// Testbench top: drives id requests and response stalls, gives the verdict.
module lowest_free_id_allocator_test;
  import lfa_pkg::*;

  localparam int         RANDOM_ITEMS = 950;
  localparam int         NARROW_ITEMS = 320;
  localparam int         LONG_HOLD    = 300;
  localparam int         IDLE_LIMIT   = 3000;
  localparam int         DRAIN_CYCLES = 40;
  localparam logic [1:0] MODE_SPARE   = 2'd3;
  localparam logic [ID_W-1:0] TOP_ID  = ID_W'(MAX_IDS);

  typedef enum {FLOW, COIN, TRICKLE} stall_mode_e;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   grants_due;
  int   items_sent    = 0;
  int   burst_left    = 0;
  int   hold_requests = 0;
  int   holds_done    = 0;
  int   idle_cycles   = 0;
  int   directed_end;

  lfa_req_if in_req ();
  lfa_rsp_if out_rsp ();

  lowest_free_id_allocator uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  id_grant_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (in_req),
    .rsp_mon    (out_rsp),
    .fail_count (fail_count),
    .grants_due (grants_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one request; called and returns at a falling edge
  task automatic send_req(input logic [1:0] mode, input logic [ID_W-1:0] id);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_req.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_req.valid  <= 1'b1;
    in_req.mode   <= mode;
    in_req.req_id <= id;
    do @(posedge clk); while (!in_req.ready);
    @(negedge clk);
    items_sent++;
    // ask the receiver for a long hold-off now and then
    if (items_sent == 260 || items_sent == 720)
      hold_requests++;
  endtask

  // Any id value, including out-of-range ones
  function automatic logic [ID_W-1:0] any_id();
    return ID_W'($urandom_range(0, MAX_IDS));
  endfunction

  // Early on stay in a narrow window so the high-water mark grows slowly
  function automatic logic [ID_W-1:0] pick_id(input bit wide);
    if (!wide)
      return ID_W'($urandom_range(1, 48));
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return 1;
      2:       return TOP_ID;
      3:       return TOP_ID - 1'b1;
      default: return ID_W'($urandom_range(1, MAX_IDS));
    endcase
  endfunction

  // One random run of a kind: allocate runs, release/reuse churn, claims, noise
  task automatic random_run(input bit wide);
    int n;
    n = $urandom_range(4, 24);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        repeat (n) send_req(MODE_ALLOC, any_id());
      end
      3, 4, 5: begin
        repeat (n) begin
          send_req(MODE_RELEASE, pick_id(wide));
          if ($urandom_range(0, 1))
            send_req(MODE_ALLOC, any_id());
        end
      end
      6, 7: begin
        repeat (n) send_req(MODE_CLAIM, pick_id(wide));
      end
      default: begin
        repeat (n) send_req(2'($urandom_range(0, 3)), any_id());
      end
    endcase
  endtask

  // Stimulus: reset, directed cases, random runs, drain, verdict
  initial begin
    rst_n         = 1'b0;
    in_req.valid  = 1'b0;
    in_req.mode   = MODE_ALLOC;
    in_req.req_id = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // fresh pool hands out 1, 2, 3 in order
    send_req(MODE_ALLOC, '0);
    send_req(MODE_ALLOC, TOP_ID);
    send_req(MODE_ALLOC, '0);
    // claim of a held id, claim and release of id 0, release of an unused top id
    send_req(MODE_CLAIM, 2);
    send_req(MODE_CLAIM, '0);
    send_req(MODE_RELEASE, '0);
    send_req(MODE_RELEASE, TOP_ID);
    // claim jumps the high-water mark; skipped ids stay out of allocation
    send_req(MODE_CLAIM, 9);
    send_req(MODE_ALLOC, '0);
    send_req(MODE_CLAIM, 5);
    // release, double release, then reuse lowest freed first
    send_req(MODE_RELEASE, 2);
    send_req(MODE_RELEASE, 2);
    send_req(MODE_RELEASE, 1);
    send_req(MODE_ALLOC, '0);
    send_req(MODE_ALLOC, '0);
    send_req(MODE_ALLOC, '0);
    // claim of a freed id must drop it from the freed pool
    send_req(MODE_RELEASE, 3);
    send_req(MODE_CLAIM, 3);
    send_req(MODE_ALLOC, '0);
    // spare mode is a no-op
    send_req(MODE_SPARE, TOP_ID);
    send_req(MODE_SPARE, '0);
    send_req(MODE_RELEASE, TOP_ID - 1'b1);
    directed_end = items_sent;

    while (items_sent < directed_end + RANDOM_ITEMS)
      random_run(items_sent >= directed_end + NARROW_ITEMS);
    in_req.valid <= 1'b0;

    wait (grants_due == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && grants_due == 0)
      $display("lowest_free_id_allocator_test: clean");
    else
      $display("lowest_free_id_allocator_test: errors");
    $finish;
  end

  // Response side: free flow, coin-flip and trickle segments, plus long hold-offs
  initial begin
    int          seg_left;
    int          hold_left;
    stall_mode_e seg_mode;
    seg_left      = 0;
    hold_left     = 0;
    seg_mode      = FLOW;
    out_rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_rsp.ready <= 1'b0;
        hold_left--;
      end else if (hold_requests > holds_done) begin
        holds_done++;
        hold_left = LONG_HOLD - 1;
        out_rsp.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_mode = stall_mode_e'($urandom_range(0, 2));
          seg_left = $urandom_range(30, 250);
        end
        seg_left--;
        case (seg_mode)
          FLOW:    out_rsp.ready <= 1'b1;
          COIN:    out_rsp.ready <= 1'($urandom_range(0, 1));
          default: out_rsp.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("lowest_free_id_allocator_test: errors");
      $finish;
    end
  end

endmodule
